// ===== design/kwm_pkg.sv =====
package kwm_pkg;

    // Fixed field widths
    localparam int VALUE_BITS = 16;
    localparam int LIDX_BITS  = 3;
    localparam int CNT_BITS   = 4;
    localparam int MAX_ACTIVE = 8;

    // Operation codes
    localparam logic OP_ELEMENT = 1'b0;
    localparam logic OP_DECLARE = 1'b1;

    // Register indexes
    localparam logic REG_LIST_COUNT = 1'b0;

    typedef struct packed {
        logic                          operation;
        logic [LIDX_BITS-1:0]          list_index;
        logic signed [VALUE_BITS-1:0]  element_value;
        logic                          final_of_list;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0]  merged_value;
        logic [LIDX_BITS-1:0]          source_list;
        logic                          has_value;
        logic                          merge_done;
        logic                          protocol_error;
        logic                          last_of_run;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic load;      // take the request into the slots
        logic emit;      // pop smallest head into pending, push old pending out
        logic finish;    // write pending (or bare result) as last of run
        logic set_done;  // mark the finished result as merge done
        logic clear;     // clear all slots
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic item_err;
        logic heads_ready;
        logic all_done;
        logic pend_valid;
        logic out_free;
        logic cap_hit;
    } t_dp_stat;

endpackage

// ===== design/k_way_sorted_merge.sv =====
// A request that releases values passes each one through the pending register into the
// output register; an error result also waits in pending, while a bare done result is
// written straight to the output register. Output stalls hold further results back.
// A new request is taken only after the controller is back in idle; each emission is
// one pass of the 8-leaf min tree.
// Reset (i_rst_n low, synchronous): all slots empty, list_count = 8, no result.
module k_way_sorted_merge #(
    parameter int LISTS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  kwm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output kwm_pkg::t_out o_out_data
);
    import kwm_pkg::*;

    logic [CNT_BITS-1:0] r_list_count;
    t_dp_cmd             cmd;
    t_dp_stat            stat;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_count <= CNT_BITS'(MAX_ACTIVE);
        end else if (psel && penable && pwrite && (paddr[2] == REG_LIST_COUNT)) begin
            r_list_count <= pwdata[CNT_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIST_COUNT) ? {{(32-CNT_BITS){1'b0}}, r_list_count}
                                                 : 32'd0;

    kwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    kwm_datapath #(
        .LISTS (LISTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_data    (i_in_data),
        .i_list_count (r_list_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== design/kwm_datapath.sv =====
module kwm_datapath #(
    parameter int LISTS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kwm_pkg::t_dp_cmd                 i_cmd,
    output kwm_pkg::t_dp_stat                o_stat,
    input  kwm_pkg::t_in                     i_in_data,
    input  logic [kwm_pkg::CNT_BITS-1:0]     i_list_count,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output kwm_pkg::t_out                    o_out_data
);
    import kwm_pkg::*;

    localparam int SLOTS = (LISTS < MAX_ACTIVE) ? LISTS : MAX_ACTIVE;

    typedef struct packed {
        logic                          vld;
        logic signed [VALUE_BITS-1:0]  val;
        logic [LIDX_BITS-1:0]          idx;
    } t_node;

    function automatic t_node pick(input t_node a, input t_node b);
        t_node r;
        r = a;
        if (b.vld && (!a.vld || (b.val < a.val))) begin
            r = b;
        end
        return r;
    endfunction

    logic signed [VALUE_BITS-1:0] r_head_value [SLOTS];
    logic [SLOTS-1:0]             r_head_valid;
    logic [SLOTS-1:0]             r_head_final;
    logic [SLOTS-1:0]             r_exhausted;
    t_out                         r_pend;
    logic                         r_pend_valid;
    t_out                         r_out;
    logic                         r_out_valid;
    logic [CNT_BITS-1:0]          r_emit_cnt;

    logic [CNT_BITS-1:0]          act_n;
    logic [SLOTS-1:0]             active;
    logic                         out_free;
    logic                         out_write;
    t_out                         out_next;
    t_node                        leaf [MAX_ACTIVE];
    t_node                        lvl1 [4];
    t_node                        lvl2 [2];
    t_node                        best;
    logic                         tgt_busy;
    logic                         heads_ready;
    logic                         all_done;
    logic                         item_err;

    // Active list count: zero acts as one, saturate at slot count
    always_comb begin
        if (i_list_count == '0) begin
            act_n = CNT_BITS'(1);
        end else if (i_list_count > CNT_BITS'(SLOTS)) begin
            act_n = CNT_BITS'(SLOTS);
        end else begin
            act_n = i_list_count;
        end
    end

    // Leaves of the compare tree, padded to eight
    genvar g;
    generate
        for (g = 0; g < MAX_ACTIVE; g++) begin : g_leaf
            if (g < SLOTS) begin : g_real
                assign active[g] = (CNT_BITS'(g) < act_n);
                assign leaf[g]   = {active[g] && r_head_valid[g], r_head_value[g],
                                    LIDX_BITS'(g)};
            end else begin : g_pad
                assign leaf[g] = '0;
            end
        end
    endgenerate

    // Three-level min tree, ties to the lower index
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            lvl1[i] = pick(leaf[2*i], leaf[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
        end
        best = pick(lvl2[0], lvl2[1]);
    end

    // Readiness and completion over the active slots
    always_comb begin
        heads_ready = 1'b1;
        all_done    = 1'b1;
        tgt_busy    = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (active[i]) begin
                if (!r_head_valid[i] && !r_exhausted[i]) begin
                    heads_ready = 1'b0;
                end
                if (r_head_valid[i] || !r_exhausted[i]) begin
                    all_done = 1'b0;
                end
            end
            if (i_in_data.list_index == LIDX_BITS'(i)) begin
                tgt_busy = r_head_valid[i] || r_exhausted[i];
            end
        end
        item_err = (CNT_BITS'(i_in_data.list_index) >= act_n) || tgt_busy;
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign o_stat   = '{item_err:    item_err,
                        heads_ready: heads_ready,
                        all_done:    all_done,
                        pend_valid:  r_pend_valid,
                        out_free:    out_free,
                        cap_hit:     (r_emit_cnt >= CNT_BITS'(MAX_ACTIVE))};

    // Next output result
    always_comb begin
        out_write = i_cmd.finish || (i_cmd.emit && r_pend_valid);
        out_next  = r_pend;
        if (i_cmd.finish) begin
            if (!r_pend_valid) begin
                out_next = '0;
            end
            out_next.last_of_run = 1'b1;
            if (i_cmd.set_done) begin
                out_next.merge_done = 1'b1;
            end
        end
    end

    // Head slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= '0;
            r_head_final <= '0;
            r_exhausted  <= '0;
        end else if (i_cmd.clear) begin
            r_head_valid <= '0;
            r_head_final <= '0;
            r_exhausted  <= '0;
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (i_cmd.load && !item_err
                        && (i_in_data.list_index == LIDX_BITS'(i))) begin
                    if (i_in_data.operation == OP_DECLARE) begin
                        r_exhausted[i] <= 1'b1;
                    end else begin
                        r_head_valid[i] <= 1'b1;
                        r_head_final[i] <= i_in_data.final_of_list;
                    end
                end
                if (i_cmd.emit && (best.idx == LIDX_BITS'(i))) begin
                    r_head_valid[i] <= 1'b0;
                    r_head_final[i] <= 1'b0;
                    if (r_head_final[i]) begin
                        r_exhausted[i] <= 1'b1;
                    end
                end
            end
        end
    end

    // Head values, read only while valid
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (i_cmd.load && !item_err && (i_in_data.operation == OP_ELEMENT)
                    && (i_in_data.list_index == LIDX_BITS'(i))) begin
                r_head_value[i] <= i_in_data.element_value;
            end
        end
    end

    // Pending result and emission count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_emit_cnt   <= '0;
        end else if (i_cmd.load) begin
            r_emit_cnt   <= '0;
            r_pend_valid <= item_err;
        end else if (i_cmd.emit) begin
            r_emit_cnt   <= r_emit_cnt + CNT_BITS'(1);
            r_pend_valid <= 1'b1;
        end else if (i_cmd.finish) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pend                <= '0;
            r_pend.protocol_error <= 1'b1;
            r_pend.last_of_run    <= 1'b1;
        end else if (i_cmd.emit) begin
            r_pend              <= '0;
            r_pend.merged_value <= best.val;
            r_pend.source_list  <= best.idx;
            r_pend.has_value    <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_write) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_write_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_write |-> out_free)
        else $error("result written while output register is held");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_head_valid == '0) && (r_exhausted == '0))
        else $error("slots not cleared after merge done");

    a_err_is_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.protocol_error |-> !r_out.has_value && r_out.last_of_run)
        else $error("error result carries a value or is not last");

    a_emit_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> best.vld && heads_ready)
        else $error("emission without a ready head");

endmodule

// ===== design/kwm_ctrl.sv =====
module kwm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  kwm_pkg::t_dp_stat  i_stat,
    output kwm_pkg::t_dp_cmd   o_cmd
);
    import kwm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.item_err ? S_FLUSH : S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.all_done) begin
                    if (i_stat.out_free) begin
                        o_cmd.finish   = 1'b1;
                        o_cmd.set_done = 1'b1;
                        o_cmd.clear    = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (!i_stat.heads_ready || i_stat.cap_hit) begin
                    if (!i_stat.pend_valid) begin
                        n_state = S_IDLE;
                    end else if (i_stat.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    // State and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule
